// ===== design/ctsc_pkg.sv =====
// Shared constants, types and helpers of the column to span converter.
`default_nettype none

package ctsc_pkg;

    localparam int ROWS         = 64;
    localparam int COLUMN_LIMIT = 1024;

    localparam int ROW_W  = $clog2(ROWS);
    localparam int X_W    = 10;
    localparam int XL_W   = X_W + 1;
    localparam int FROW_W = 6;
    localparam int EXT_W  = 8;

    localparam logic [EXT_W-1:0] EMPTY_TOP = 8'hff;
    localparam logic [EXT_W-1:0] ROWS_E    = EXT_W'(ROWS);
    localparam logic [EXT_W-1:0] ROW_MAX_E = EXT_W'(ROWS - 1);
    localparam logic [XL_W-1:0]  LIMIT_E   = XL_W'(COLUMN_LIMIT);
    localparam logic [X_W-1:0]   X_LAST    = X_W'(COLUMN_LIMIT - 1);

    typedef struct packed {
        logic [ROW_W-1:0] tag;
        logic [X_W-1:0]   start;
    } t_cell_data;

    typedef struct packed {
        logic fwd;
        logic back;
    } t_shift;

    typedef struct packed {
        logic             en;
        logic [EXT_W-1:0] t1;
        logic [EXT_W-1:0] b1;
        logic [EXT_W-1:0] t2;
        logic [EXT_W-1:0] b2;
        logic [X_W-1:0]   x;
    } t_open;

endpackage

`default_nettype wire

// ===== design/ctsc_col_if.sv =====
// Column channel: valid/ready handshake carrying one column extent per item.
`default_nettype none

interface ctsc_col_if import ctsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [X_W-1:0]    column_x;
    logic [FROW_W-1:0] column_top;
    logic [FROW_W-1:0] column_bottom;
    logic              column_empty;
    logic              plane_start;

    modport source (
        output valid, column_x, column_top, column_bottom, column_empty, plane_start,
        input  ready
    );
    modport sink (
        input  valid, column_x, column_top, column_bottom, column_empty, plane_start,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/ctsc_span_if.sv =====
// Span channel: valid/ready handshake carrying one closed span per item.
`default_nettype none

interface ctsc_span_if import ctsc_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [FROW_W-1:0] span_row;
    logic [X_W-1:0]    span_start_x;
    logic [X_W-1:0]    span_end_x;
    logic              last_span;

    modport source (
        output valid, span_row, span_start_x, span_end_x, last_span,
        input  ready
    );
    modport sink (
        input  valid, span_row, span_start_x, span_end_x, last_span,
        output ready
    );
endinterface

`default_nettype wire

// ===== design/column_to_span_converter.sv =====
// Top level: column extents in, closed horizontal spans out, over a ring of row cells.
`default_nettype none

// Usage
// i_col takes one screen column per item (x, top, bottom, empty flag, plane start),
// left to right within a plane. o_span returns one item per closed row: the row, the
// column where its span began and the column before the current one; last_span marks
// the final span that a column causes. A column that closes no row yields no item.
// Rows closed above the new top come out in ascending order, then rows closed below
// the new bottom in descending order. Send an empty column after the plane's last
// column to flush all open spans.
// Span starts live in a ring of ROWS cells that rotates one step per cycle in either
// direction unless a stalled receiver holds the walk; only the cell at the head of the
// ring is read. A column is registered, then reduced modulo COLUMN_LIMIT, then the newly
// covered rows are written; then the head seeks the first closed row by the shorter way
// round, walks the top rows, seeks the bottom-most closed row and walks back.
// i_col.ready is high only between columns.
// Reset clears the previous extent to empty, rewinds the ring and drops any pending
// span; span starts are not cleared. A stalled receiver holds the output register
// and halts the walk, but the next column is taken once the walk is done.

module column_to_span_converter import ctsc_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ctsc_col_if.sink     i_col,
    ctsc_span_if.source  o_span
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_OPEN,
        S_TOP,
        S_BOT
    } t_state;

    t_state r_state, n_state;

    // previous column extent
    logic             r_prev_empty, n_prev_empty;
    logic [ROW_W-1:0] r_prev_top, n_prev_top;
    logic [ROW_W-1:0] r_prev_bot, n_prev_bot;

    // old (t1, b1) and new (t2, b2) extents of the column at work
    logic [EXT_W-1:0] r_t1, n_t1;
    logic [EXT_W-1:0] r_b1, n_b1;
    logic [EXT_W-1:0] r_t2, n_t2;
    logic [EXT_W-1:0] r_b2, n_b2;
    logic [X_W-1:0]   r_x, n_x;

    // close ranges: top rows ascending, bottom rows descending
    logic             r_a_on, n_a_on;
    logic [ROW_W-1:0] r_a_last, n_a_last;
    logic             r_b_on, n_b_on;
    logic [ROW_W-1:0] r_b_last, n_b_last;
    logic [ROW_W-1:0] r_cur, n_cur;

    // output register
    logic              r_out_valid, n_out_valid;
    logic [FROW_W-1:0] r_span_row, n_span_row;
    logic [X_W-1:0]    r_span_start, n_span_start;
    logic [X_W-1:0]    r_span_end, n_span_end;
    logic              r_span_last, n_span_last;

    // ring
    t_cell_data w_cell [ROWS];
    t_shift     w_shift;
    t_open      w_open;

    logic             w_accept;
    logic             w_top_ok;
    logic [EXT_W-1:0] w_top_e;
    logic [EXT_W-1:0] w_bot_e;
    logic [EXT_W-1:0] w_a_last;
    logic [EXT_W-1:0] w_t1p;
    logic [EXT_W-1:0] w_b_last;
    logic             w_a_on;
    logic             w_b_on;
    logic [XL_W-1:0]  w_x_e;
    logic [X_W-1:0]   w_endx;
    logic [ROW_W-1:0] w_head;
    logic             w_at;
    logic [ROW_W:0]   w_fwd_dist;
    logic             w_go_fwd;
    logic             w_out_free;
    logic             w_emit;
    logic             w_emit_last;

    assign w_accept   = i_col.valid && i_col.ready;
    assign w_head     = w_cell[0].tag;
    assign w_at       = (w_head == r_cur);
    assign w_out_free = !r_out_valid || o_span.ready;
    assign w_x_e      = {1'b0, r_x};
    assign w_endx     = (r_x == '0) ? X_LAST : r_x - X_W'(1);

    // shorter way round to the target row
    assign w_fwd_dist = (r_cur >= w_head) ?
                        ({1'b0, r_cur} - {1'b0, w_head}) :
                        ({1'b0, r_cur} + (ROW_W + 1)'(ROWS) - {1'b0, w_head});
    assign w_go_fwd   = (w_fwd_dist <= (ROW_W + 1)'(ROWS / 2));

    always_comb begin
        // extents of the incoming column
        w_top_e  = EXT_W'(i_col.column_top);
        w_bot_e  = EXT_W'(i_col.column_bottom);
        w_top_ok = !i_col.column_empty && (w_top_e < ROWS_E);

        // close ranges from the registered extents
        w_a_on   = (r_t1 < r_t2) && (r_t1 <= r_b1);
        w_a_last = ((r_t2 - EXT_W'(1)) < r_b1) ? (r_t2 - EXT_W'(1)) : r_b1;
        w_t1p    = w_a_on ? (w_a_last + EXT_W'(1)) : r_t1;
        w_b_on   = (r_b1 > r_b2) && (r_b1 >= w_t1p);
        w_b_last = ((r_b2 + EXT_W'(1)) > w_t1p) ? (r_b2 + EXT_W'(1)) : w_t1p;

        n_state      = r_state;
        n_prev_empty = r_prev_empty;
        n_prev_top   = r_prev_top;
        n_prev_bot   = r_prev_bot;
        n_t1         = r_t1;
        n_b1         = r_b1;
        n_t2         = r_t2;
        n_b2         = r_b2;
        n_x          = r_x;
        n_a_on       = r_a_on;
        n_a_last     = r_a_last;
        n_b_on       = r_b_on;
        n_b_last     = r_b_last;
        n_cur        = r_cur;
        w_shift      = '{fwd: 1'b0, back: 1'b0};
        w_emit       = 1'b0;
        w_emit_last  = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_top_ok) begin
                        n_t2 = w_top_e;
                        n_b2 = (w_bot_e > ROW_MAX_E) ? ROW_MAX_E : w_bot_e;
                    end else begin
                        n_t2 = EMPTY_TOP;
                        n_b2 = '0;
                    end
                    if (i_col.plane_start || r_prev_empty) begin
                        n_t1 = EMPTY_TOP;
                        n_b1 = '0;
                    end else begin
                        n_t1 = EXT_W'(r_prev_top);
                        n_b1 = EXT_W'(r_prev_bot);
                    end
                    n_prev_empty = !w_top_ok;
                    n_prev_top   = w_top_ok ? n_t2[ROW_W-1:0] : '0;
                    n_prev_bot   = n_b2[ROW_W-1:0];
                    n_x          = i_col.column_x;
                    n_state      = S_MOD;
                end
            end
            S_MOD: begin
                // reduce the column one subtraction a cycle; latch the close ranges
                n_a_on   = w_a_on;
                n_a_last = w_a_last[ROW_W-1:0];
                n_b_on   = w_b_on;
                n_b_last = w_b_last[ROW_W-1:0];
                if (w_x_e >= LIMIT_E) begin
                    n_x = X_W'(w_x_e - LIMIT_E);
                end else begin
                    n_state = S_OPEN;
                end
            end
            S_OPEN: begin
                // newly covered rows are written by the cells this cycle
                if (r_a_on) begin
                    n_cur   = r_t1[ROW_W-1:0];
                    n_state = S_TOP;
                end else if (r_b_on) begin
                    n_cur   = r_b1[ROW_W-1:0];
                    n_state = S_BOT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_TOP: begin
                if (w_at) begin
                    if (w_out_free) begin
                        w_emit      = 1'b1;
                        w_emit_last = (r_cur == r_a_last) && !r_b_on;
                        w_shift.fwd = 1'b1;
                        if (r_cur == r_a_last) begin
                            if (r_b_on) begin
                                n_cur   = r_b1[ROW_W-1:0];
                                n_state = S_BOT;
                            end else begin
                                n_state = S_IDLE;
                            end
                        end else begin
                            n_cur = r_cur + ROW_W'(1);
                        end
                    end
                end else begin
                    w_shift.fwd  = w_go_fwd;
                    w_shift.back = !w_go_fwd;
                end
            end
            S_BOT: begin
                if (w_at) begin
                    if (w_out_free) begin
                        w_emit       = 1'b1;
                        w_emit_last  = (r_cur == r_b_last);
                        w_shift.back = 1'b1;
                        if (r_cur == r_b_last) begin
                            n_state = S_IDLE;
                        end else begin
                            n_cur = r_cur - ROW_W'(1);
                        end
                    end
                end else begin
                    w_shift.fwd  = w_go_fwd;
                    w_shift.back = !w_go_fwd;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // output register: load on emit, drop once taken
        n_out_valid  = r_out_valid;
        n_span_row   = r_span_row;
        n_span_start = r_span_start;
        n_span_end   = r_span_end;
        n_span_last  = r_span_last;
        if (w_emit) begin
            n_out_valid  = 1'b1;
            n_span_row   = FROW_W'(w_cell[0].tag);
            n_span_start = w_cell[0].start;
            n_span_end   = w_endx;
            n_span_last  = w_emit_last;
        end else if (o_span.ready) begin
            n_out_valid  = 1'b0;
        end
    end

    assign w_open = '{en: (r_state == S_OPEN), t1: r_t1, b1: r_b1, t2: r_t2, b2: r_b2,
                      x: r_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_prev_empty <= 1'b1;
            r_prev_top   <= '0;
            r_prev_bot   <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_prev_empty <= n_prev_empty;
            r_prev_top   <= n_prev_top;
            r_prev_bot   <= n_prev_bot;
            r_out_valid  <= n_out_valid;
        end
        r_t1         <= n_t1;
        r_b1         <= n_b1;
        r_t2         <= n_t2;
        r_b2         <= n_b2;
        r_x          <= n_x;
        r_a_on       <= n_a_on;
        r_a_last     <= n_a_last;
        r_b_on       <= n_b_on;
        r_b_last     <= n_b_last;
        r_cur        <= n_cur;
        r_span_row   <= n_span_row;
        r_span_start <= n_span_start;
        r_span_end   <= n_span_end;
        r_span_last  <= n_span_last;
    end

    // ring of row cells; forward rotation moves the head to the next higher row
    for (genvar i = 0; i < ROWS; i++) begin : g_cell
        ctsc_row_cell u_cell (
            .i_clk       (i_clk),
            .i_rst_n     (i_rst_n),
            .i_tag_init  (ROW_W'(i)),
            .i_shift     (w_shift),
            .i_open      (w_open),
            .i_from_up   (w_cell[(i + 1) % ROWS]),
            .i_from_down (w_cell[(i + ROWS - 1) % ROWS]),
            .o_data      (w_cell[i])
        );
    end

    assign i_col.ready         = (r_state == S_IDLE);
    assign o_span.valid        = r_out_valid;
    assign o_span.span_row     = r_span_row;
    assign o_span.span_start_x = r_span_start;
    assign o_span.span_end_x   = r_span_end;
    assign o_span.last_span    = r_span_last;

    a_accept_to_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_MOD))
        else $error("accepted column did not enter modulo reduction");

    a_last_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_emit_last) |=> (r_state == S_IDLE))
        else $error("walk continued after last span");

    a_one_dir: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_shift.fwd && w_shift.back))
        else $error("ring rotated both ways");

    a_top_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_TOP) |-> (r_cur <= r_a_last))
        else $error("top walk past its last row");

    a_bot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BOT) |-> (r_cur >= r_b_last))
        else $error("bottom walk past its last row");

endmodule

`default_nettype wire

// ===== design/ctsc_row_cell.sv =====
// One cell of the rotating row ring: holds a row tag and that row's span start.
`default_nettype none

module ctsc_row_cell import ctsc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [ROW_W-1:0] i_tag_init,
    input  t_shift           i_shift,
    input  t_open            i_open,
    input  t_cell_data       i_from_up,
    input  t_cell_data       i_from_down,
    output t_cell_data       o_data
);

    logic [ROW_W-1:0] r_tag;
    logic [X_W-1:0]   r_start;
    logic [ROW_W-1:0] n_tag;
    logic [X_W-1:0]   n_start;
    t_cell_data       w_sel;
    logic [EXT_W-1:0] w_tag_e;
    logic             w_in_new;
    logic             w_in_old;

    always_comb begin
        if (i_shift.fwd) begin
            w_sel = i_from_up;
        end else if (i_shift.back) begin
            w_sel = i_from_down;
        end else begin
            w_sel = '{tag: r_tag, start: r_start};
        end
        w_tag_e  = EXT_W'(w_sel.tag);
        w_in_new = (w_tag_e >= i_open.t2) && (w_tag_e <= i_open.b2);
        w_in_old = (w_tag_e >= i_open.t1) && (w_tag_e <= i_open.b1);
        n_tag    = w_sel.tag;
        // open: rows covered now but not before take the current column
        n_start  = (i_open.en && w_in_new && !w_in_old) ? i_open.x : w_sel.start;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag <= i_tag_init;
        end else begin
            r_tag <= n_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        r_start <= n_start;
    end

    assign o_data = '{tag: r_tag, start: r_start};

endmodule

`default_nettype wire
